FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define CKD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define CKD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/ckd_pkg.sv
package ckd_pkg;

    typedef struct packed {
        logic vol_enc_a;
        logic vol_enc_b;
        logic push_key;
        logic left_key;
        logic right_key;
        logic down_key;
        logic up_key;
        logic nav_enc_a;
        logic nav_enc_b;
        logic spare_line;
        logic vol_key;
    } ckd_snap_t;

    typedef struct packed {
        logic [3:0] event_code;
    } ckd_evt_t;

    typedef enum logic [3:0] {
        EV_NONE     = 4'd0,
        EV_VOLPRESS = 4'd1,
        EV_PRESS    = 4'd2,
        EV_RELEASE  = 4'd3,
        EV_CW       = 4'd4,
        EV_CCW      = 4'd5,
        EV_DOWN     = 4'd6,
        EV_UP       = 4'd7,
        EV_LEFT     = 4'd8,
        EV_RIGHT    = 4'd9,
        EV_VOLCW    = 4'd10,
        EV_VOLCCW   = 4'd11
    } ckd_event_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_CW   = 2'd1,
        DIR_CCW  = 2'd2
    } ckd_dir_t;

    localparam int LEVEL_W = 10;

    // Bit positions in the remembered level vector
    localparam logic [3:0] B_VA    = 4'd0;
    localparam logic [3:0] B_VB    = 4'd1;
    localparam logic [3:0] B_PUSH  = 4'd2;
    localparam logic [3:0] B_LEFT  = 4'd3;
    localparam logic [3:0] B_RIGHT = 4'd4;
    localparam logic [3:0] B_DOWN  = 4'd5;
    localparam logic [3:0] B_UP    = 4'd6;
    localparam logic [3:0] B_NA    = 4'd7;
    localparam logic [3:0] B_NB    = 4'd8;
    localparam logic [3:0] B_VKEY  = 4'd9;

    typedef struct packed {
        ckd_snap_t            last_snap;
        logic                 last_valid;
        logic [LEVEL_W-1:0]   qprev;
        logic                 primed;
    } ckd_state_t;

    // Position on the Gray cycle 00, 10, 11, 01 (a, b)
    function automatic logic [1:0] quad_pos(input logic a, input logic b);
        logic [1:0] p;
        if (!a)
        begin
            p = b ? 2'd3 : 2'd0;
        end
        else
        begin
            p = b ? 2'd2 : 2'd1;
        end
        return p;
    endfunction

    function automatic ckd_dir_t quad_step(input logic pa, input logic pb,
                                           input logic ca, input logic cb);
        logic [1:0] p;
        logic [1:0] c;
        ckd_dir_t   d;
        p = quad_pos(pa, pb);
        c = quad_pos(ca, cb);
        if (c == p + 2'd1)
        begin
            d = DIR_CW;
        end
        else if (c == p + 2'd3)
        begin
            d = DIR_CCW;
        end
        else
        begin
            d = DIR_NONE;
        end
        return d;
    endfunction

endpackage

FILE: hdl/ckd_snap_if.sv
interface ckd_snap_if import ckd_pkg::*; ();
    logic      valid;
    logic      ready;
    ckd_snap_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/ckd_evt_if.sv
interface ckd_evt_if import ckd_pkg::*; ();
    logic     valid;
    logic     ready;
    ckd_evt_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/control_knob_event_decoder.sv
// Channel   Role   Payload                                  Beat
// snap      sink   eleven panel line levels (ckd_snap_t)    valid && ready
// evt       source event_code, 4 bits (ckd_evt_t)           valid && ready
//
// One beat per cycle sustained while evt is not stalled; a snapshot passes through the input
// register, then decode into the result register.
// Decode state (last snapshot, remembered levels, primed flag) is read and
// written in the same cycle a beat enters the result register.
// Reset clears all valid flags and decode state.
// A stall on evt holds the result; snap keeps accepting until both registers fill.
module control_knob_event_decoder import ckd_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    ckd_snap_if.sink   snap,
    ckd_evt_if.source  evt
);

    logic       hold_valid;
    logic       hold_ready;
    ckd_snap_t  hold_data;
    ckd_state_t st;
    ckd_state_t st_next;
    ckd_event_t code;

    ckd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (snap.valid),
        .in_ready   (snap.ready),
        .in_data    (snap.data),
        .hold_valid (hold_valid),
        .hold_ready (hold_ready),
        .hold_data  (hold_data)
    );

    ckd_decode u_dec (
        .snap    (hold_data),
        .st      (st),
        .st_next (st_next),
        .code    (code)
    );

    ckd_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .hold_valid (hold_valid),
        .hold_ready (hold_ready),
        .st_next    (st_next),
        .code       (code),
        .st         (st),
        .out_valid  (evt.valid),
        .out_ready  (evt.ready),
        .out_data   (evt.data)
    );

endmodule

FILE: hdl/ckd_in_stage.sv
module ckd_in_stage import ckd_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  ckd_snap_t in_data,
    output logic      hold_valid,
    input  logic      hold_ready,
    output ckd_snap_t hold_data
);

    logic      valid_reg;
    ckd_snap_t data_reg;

    assign in_ready   = !valid_reg || hold_ready;
    assign hold_valid = valid_reg;
    assign hold_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_data;
        end
    end

endmodule

FILE: hdl/ckd_decode.sv
module ckd_decode import ckd_pkg::*; (
    input  ckd_snap_t  snap,
    input  ckd_state_t st,
    output ckd_state_t st_next,
    output ckd_event_t code
);

    logic [LEVEL_W-1:0] lv;
    logic [LEVEL_W-1:0] q;
    logic               hit;
    ckd_dir_t           nav_dir;
    ckd_dir_t           vol_dir;

    always_comb
    begin
        lv[B_VA]    = snap.vol_enc_a;
        lv[B_VB]    = snap.vol_enc_b;
        lv[B_PUSH]  = snap.push_key;
        lv[B_LEFT]  = snap.left_key;
        lv[B_RIGHT] = snap.right_key;
        lv[B_DOWN]  = snap.down_key;
        lv[B_UP]    = snap.up_key;
        lv[B_NA]    = snap.nav_enc_a;
        lv[B_NB]    = snap.nav_enc_b;
        lv[B_VKEY]  = snap.vol_key;
    end

    assign nav_dir = quad_step(st.qprev[B_NA], st.qprev[B_NB], lv[B_NA], lv[B_NB]);
    assign vol_dir = quad_step(st.qprev[B_VA], st.qprev[B_VB], lv[B_VA], lv[B_VB]);

    // Priority chain: each key check reached updates its remembered level; encoder levels update only on a step
    always_comb
    begin
        st_next = st;
        code    = EV_NONE;
        q       = st.qprev;
        hit     = 1'b0;
        if (!st.primed)
        begin
            st_next.primed = 1'b1;
            st_next.qprev  = lv;
        end
        else if (!(st.last_valid && (snap == st.last_snap)))
        begin
            st_next.last_snap  = snap;
            st_next.last_valid = 1'b1;

            q[B_VKEY] = lv[B_VKEY];
            if (lv[B_VKEY] && !st.qprev[B_VKEY])
            begin
                code = EV_VOLPRESS;
                hit  = 1'b1;
            end

            if (!hit)
            begin
                q[B_PUSH] = lv[B_PUSH];
                if (lv[B_PUSH] && !st.qprev[B_PUSH])
                begin
                    code = EV_PRESS;
                    hit  = 1'b1;
                end
                else if (!lv[B_PUSH] && st.qprev[B_PUSH])
                begin
                    code = EV_RELEASE;
                    hit  = 1'b1;
                end
            end

            if (!hit && nav_dir != DIR_NONE)
            begin
                q[B_NA] = lv[B_NA];
                q[B_NB] = lv[B_NB];
                code    = (nav_dir == DIR_CW) ? EV_CW : EV_CCW;
                hit     = 1'b1;
            end

            if (!hit)
            begin
                q[B_DOWN] = lv[B_DOWN];
                if (lv[B_DOWN] && !st.qprev[B_DOWN])
                begin
                    code = EV_DOWN;
                    hit  = 1'b1;
                end
            end

            if (!hit)
            begin
                q[B_UP] = lv[B_UP];
                if (lv[B_UP] && !st.qprev[B_UP])
                begin
                    code = EV_UP;
                    hit  = 1'b1;
                end
            end

            if (!hit)
            begin
                q[B_LEFT] = lv[B_LEFT];
                if (lv[B_LEFT] && !st.qprev[B_LEFT])
                begin
                    code = EV_LEFT;
                    hit  = 1'b1;
                end
            end

            if (!hit)
            begin
                q[B_RIGHT] = lv[B_RIGHT];
                if (lv[B_RIGHT] && !st.qprev[B_RIGHT])
                begin
                    code = EV_RIGHT;
                    hit  = 1'b1;
                end
            end

            if (!hit && vol_dir != DIR_NONE)
            begin
                q[B_VA] = lv[B_VA];
                q[B_VB] = lv[B_VB];
                code    = (vol_dir == DIR_CW) ? EV_VOLCW : EV_VOLCCW;
            end

            st_next.qprev = q;
        end
    end

endmodule

FILE: hdl/ckd_out_stage.sv
module ckd_out_stage import ckd_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       hold_valid,
    output logic       hold_ready,
    input  ckd_state_t st_next,
    input  ckd_event_t code,
    output ckd_state_t st,
    output logic       out_valid,
    input  logic       out_ready,
    output ckd_evt_t   out_data
);

    ckd_state_t st_reg;
    logic       valid_reg;
    ckd_evt_t   data_reg;
    logic       advance;

    assign hold_ready = !valid_reg || out_ready;
    assign advance    = hold_valid && hold_ready;
    assign st         = st_reg;
    assign out_valid  = valid_reg;
    assign out_data   = data_reg;

    // Commit state only when the held beat moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                st_reg <= st_next;
            end
            if (hold_ready)
            begin
                valid_reg <= hold_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg.event_code <= code;
        end
    end

endmodule

FILE: hdl/ckd_checker.sv
`include "assert_macros.svh"

module ckd_checker import ckd_pkg::*; (
    input logic     clk,
    input logic     rst_n,
    input logic     snap_valid,
    input logic     snap_ready,
    input logic     evt_valid,
    input logic     evt_ready,
    input ckd_evt_t evt_data
);

    logic [1:0] pending_reg;
    logic [1:0] pending_next;
    logic       snap_beat;
    logic       evt_beat;

    assign snap_beat = snap_valid && snap_ready;
    assign evt_beat  = evt_valid && evt_ready;

    // Track beats taken but not yet delivered
    always_comb
    begin
        pending_next = pending_reg;
        if (snap_beat && !evt_beat)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (!snap_beat && evt_beat)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `CKD_ASSERT_NOW(a_code_range, evt_valid, evt_data.event_code <= EV_VOLCCW, "event code out of range")
    `CKD_ASSERT_NOW(a_no_phantom, evt_valid, pending_reg != 2'd0, "result without a pending snapshot")
    // Both registers full and the result stalled: input must hold off
    `CKD_ASSERT_NOW(a_capacity, pending_reg == 2'd2 && !evt_ready, !snap_ready, "ready while full")
    `CKD_ASSERT_NEXT(a_evt_hold, evt_valid && !evt_ready, evt_valid && $stable(evt_data), "stalled result changed")

endmodule

bind control_knob_event_decoder ckd_checker u_ckd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_valid (snap.valid),
    .snap_ready (snap.ready),
    .evt_valid  (evt.valid),
    .evt_ready  (evt.ready),
    .evt_data   (evt.data)
);
